FILE: hdl/uart_baud_scale_step_search_unit_assert.svh
// Assertion macros for the baud scale and step search block.
`ifndef UART_BAUD_SCALE_STEP_SEARCH_UNIT_ASSERT_SVH
`define UART_BAUD_SCALE_STEP_SEARCH_UNIT_ASSERT_SVH

// Checked only out of reset.
`define UBSS_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication between two conditions, checked only out of reset.
`define UBSS_ASSERT_IMPL(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

FILE: hdl/ubss_pkg.sv
// Shared widths, limits and types for the baud scale and step search block.
`default_nettype none

package ubss_pkg;

    localparam int BAUD_W      = 24;
    localparam int CLK_W       = 28;
    localparam int SCALE_W     = 8;
    localparam int STEP_W      = 14;
    localparam int ERR_W       = 24;
    localparam int FRAC_SHIFT  = 17;

    localparam int SCALE_LIMIT = 255;
    localparam int STEP_LIMIT  = 13107;

    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(25000000);

    // width that holds any step up to the limit
    localparam int STEPC_W     = $clog2(STEP_LIMIT + 1);
    localparam int MUL_B_W     = (STEPC_W > SCALE_W) ? STEPC_W : SCALE_W;
    localparam int PROD_W      = CLK_W + MUL_B_W;
    localparam int DIVIDEND_W  = BAUD_W + SCALE_W + FRAC_SHIFT;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: hdl/ubss_if.sv
// Handshake channels: baud request, search result and clock configuration.
`default_nettype none

interface ubss_baud_if;
    import ubss_pkg::*;

    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

interface ubss_result_if;
    import ubss_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] best_scale;
    logic [STEP_W-1:0]  best_step;
    logic [ERR_W-1:0]   rate_error;

    modport source (output valid, output best_scale, output best_step, output rate_error,
                    input ready);
    modport sink   (input valid, input best_scale, input best_step, input rate_error,
                    output ready);
endinterface

interface ubss_cfg_if;
    import ubss_pkg::*;

    logic             valid;
    logic             ready;
    logic [CLK_W-1:0] clock_hz;

    modport source (output valid, output clock_hz, input ready);
    modport sink   (input valid, input clock_hz, output ready);
endinterface

`default_nettype wire

FILE: hdl/ubss_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions of a trial.
`default_nettype none

module ubss_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [ubss_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [ubss_pkg::CLK_W-1:0]      divisor,
    output      logic [ubss_pkg::DIVIDEND_W-1:0] quotient,
    output      ubss_pkg::div_status_t           status
);
    import ubss_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CLK_W-1:0]      rem_reg, rem_next;
    logic [CLK_W-1:0]      dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;

    logic [CLK_W:0]        trial;
    logic [CLK_W:0]        diff;
    logic                  fits;

    // remainder stays below the divisor, so the trial fits in one extra bit
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

FILE: hdl/uart_baud_scale_step_search_unit.sv
// Top level: sequencer, shared multiplier and result register of the baud search.
// Searches the prescale and fractional step pair closest to a requested baud rate.
// Each accepted word runs scales 0, 1, 2, ... through one shared multiplier and one
// shared bit-serial divider (49 quotient bits, up to two divisions per scale). The
// search visits at most 255 scales (0 to 254) and stops early once the step passes
// its limit. The request side is ready only between searches; a finished result
// waits in an output register while the next request is taken. A clock of zero
// skips the search and returns scale 0, step 0 and the baud rate as the error.
`default_nettype none

module uart_baud_scale_step_search_unit (
    input wire logic      clk,
    input wire logic      rst_n,
    ubss_baud_if.sink     req,
    ubss_result_if.source rsp,
    ubss_cfg_if.sink      cfg
);
    import ubss_pkg::*;

    `include "uart_baud_scale_step_search_unit_assert.svh"

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL1 = 9'b000000010,
        ST_DS1  = 9'b000000100,
        ST_DW1  = 9'b000001000,
        ST_MUL2 = 9'b000010000,
        ST_DS2  = 9'b000100000,
        ST_DW2  = 9'b001000000,
        ST_CMP  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CLK_W-1:0]    clk_hz_reg, clk_hz_next;
    logic [BAUD_W-1:0]   baud_reg, baud_next;
    logic [SCALE_W-1:0]  sc_reg, sc_next;
    logic [STEPC_W-1:0]  st_reg, st_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SCALE_W-1:0]  best_sc_reg, best_sc_next;
    logic [STEPC_W-1:0]  best_st_reg, best_st_next;
    logic [ERR_W-1:0]    best_err_reg, best_err_next;
    logic                out_valid_reg, out_valid_next;
    logic [SCALE_W-1:0]  out_sc_reg, out_sc_next;
    logic [STEP_W-1:0]   out_st_reg, out_st_next;
    logic [ERR_W-1:0]    out_err_reg, out_err_next;

    logic [SCALE_W-1:0]    scale_p1;
    logic [CLK_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W:0]       rnd_sum;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [CLK_W-1:0]      div_divisor;
    logic [DIVIDEND_W-1:0] div_quotient;
    div_status_t           div_stat;
    logic [CLK_W-1:0]      rate;
    logic [CLK_W-1:0]      baud_x;
    logic [CLK_W-1:0]      err;
    logic                  req_take;
    logic                  out_load;

    assign scale_p1 = sc_reg + 1'b1;

    // shared multiplier: baud * divider, then clock * step
    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            mul_a = clk_hz_reg;
            mul_b = MUL_B_W'(st_reg);
        end
        else
        begin
            mul_a = CLK_W'(baud_reg);
            mul_b = MUL_B_W'(scale_p1);
        end
    end

    // rounding: add half of 2^17 * divider, then drop the fraction bits
    assign rnd_sum = {1'b0, prod_reg} + ((PROD_W + 1)'(scale_p1) << (FRAC_SHIFT - 1));

    assign div_start = (state_reg == ST_DS1) || (state_reg == ST_DS2);

    always_comb
    begin
        if (state_reg == ST_DS2)
        begin
            div_dividend = DIVIDEND_W'(rnd_sum >> FRAC_SHIFT);
            div_divisor  = CLK_W'(scale_p1);
        end
        else
        begin
            div_dividend = {prod_reg[BAUD_W+SCALE_W-1:0], {FRAC_SHIFT{1'b0}}};
            div_divisor  = clk_hz_reg;
        end
    end

    ubss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    assign rate   = div_quotient[CLK_W-1:0];
    assign baud_x = CLK_W'(baud_reg);
    assign err    = (rate >= baud_x) ? (rate - baud_x) : (baud_x - rate);

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_take  = req.valid && req.ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next    = state_reg;
        clk_hz_next   = clk_hz_reg;
        baud_next     = baud_reg;
        sc_next       = sc_reg;
        st_next       = st_reg;
        prod_next     = prod_reg;
        best_sc_next  = best_sc_reg;
        best_st_next  = best_st_reg;
        best_err_next = best_err_reg;

        if (cfg.valid)
        begin
            clk_hz_next = cfg.clock_hz;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    baud_next     = req.baud_rate;
                    sc_next       = '0;
                    best_sc_next  = '0;
                    best_st_next  = '0;
                    best_err_next = req.baud_rate;
                    state_next    = (clk_hz_reg == '0) ? ST_DONE : ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_DS1;
            end
            ST_DS1:
            begin
                state_next = ST_DW1;
            end
            ST_DW1:
            begin
                if (div_stat.done)
                begin
                    if (div_quotient > DIVIDEND_W'(STEP_LIMIT))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        st_next    = STEPC_W'(div_quotient);
                        state_next = ST_MUL2;
                    end
                end
            end
            ST_MUL2:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_DS2;
            end
            ST_DS2:
            begin
                state_next = ST_DW2;
            end
            ST_DW2:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (err < CLK_W'(best_err_reg))
                begin
                    best_err_next = ERR_W'(err);
                    best_sc_next  = sc_reg;
                    best_st_next  = st_reg;
                end
                if (sc_reg == SCALE_W'(SCALE_LIMIT - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sc_next    = scale_p1;
                    state_next = ST_MUL1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sc_next    = out_sc_reg;
        out_st_next    = out_st_reg;
        out_err_next   = out_err_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sc_next    = best_sc_reg;
            out_st_next    = STEP_W'(best_st_reg);
            out_err_next   = best_err_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clk_hz_reg    <= CLK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clk_hz_reg    <= clk_hz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        baud_reg     <= baud_next;
        sc_reg       <= sc_next;
        st_reg       <= st_next;
        prod_reg     <= prod_next;
        best_sc_reg  <= best_sc_next;
        best_st_reg  <= best_st_next;
        best_err_reg <= best_err_next;
        out_sc_reg   <= out_sc_next;
        out_st_reg   <= out_st_next;
        out_err_reg  <= out_err_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.best_scale = out_sc_reg;
    assign rsp.best_step  = out_st_reg;
    assign rsp.rate_error = out_err_reg;

    `UBSS_ASSERT_IMPL(a_div_start_idle, div_start, !div_stat.busy,
        "divider restarted while busy")
    `UBSS_ASSERT_IMPL(a_step_in_range, state_reg == ST_DS2,
        st_reg <= STEPC_W'(STEP_LIMIT), "step above limit reached second division")
    `UBSS_ASSERT_IMPL(a_err_bounded, state_reg == ST_DONE,
        best_err_reg <= baud_reg, "best error exceeds requested baud")
    `UBSS_ASSERT(a_div_done_waiting, !div_stat.done || state_reg == ST_DW1 ||
        state_reg == ST_DW2, "divider finished outside a wait state")

endmodule

`default_nettype wire

FILE: tb/uart_baud_scale_step_search_unit_test.sv
// Testbench for the baud scale and step search unit: directed and random requests, scoreboard.
`timescale 1ns / 1ps

module uart_baud_scale_step_search_unit_test;
    import ubss_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_CYCLES     = 30000;
    localparam int PHASE_ITEMS    = 15;
    localparam logic [BAUD_W-1:0] BAUD_MAX = {BAUD_W{1'b1}};
    localparam logic [CLK_W-1:0]  CLK_MAX  = {CLK_W{1'b1}};

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [STEP_W-1:0]  step;
        logic [ERR_W-1:0]   err;
    } search_result_t;

    class baud_search_scoreboard;
        logic [CLK_W-1:0] clock_hz;
        search_result_t   predicted_q[$];
        int               mismatches;
        int               requests_seen;
        int               results_seen;

        function new();
            clock_hz      = CLK_RESET;
            mismatches    = 0;
            requests_seen = 0;
            results_seen  = 0;
        endfunction

        function void set_clock(logic [CLK_W-1:0] hz);
            clock_hz = hz;
        endfunction

        // Walk the scales, keep the first pair with strictly smaller error.
        function void note_request(logic [BAUD_W-1:0] baud);
            logic [63:0]    b;
            logic [63:0]    c;
            logic [63:0]    st;
            logic [63:0]    div;
            logic [63:0]    rate;
            logic [63:0]    err;
            logic [63:0]    best_err;
            logic [63:0]    best_sc;
            logic [63:0]    best_st;
            search_result_t res;
            b        = 64'(baud);
            c        = 64'(clock_hz);
            best_err = b;
            best_sc  = 0;
            best_st  = 0;
            if (c != 0) begin
                for (int sc = 0; sc < SCALE_LIMIT; sc++) begin
                    st = (b * 64'(sc + 1) * (64'd1 << FRAC_SHIFT)) / c;
                    if (st > 64'(STEP_LIMIT))
                        break;
                    div  = 64'(sc + 1) << FRAC_SHIFT;
                    rate = (c * st + div / 2) / div;
                    err  = (rate >= b) ? (rate - b) : (b - rate);
                    if (err < best_err) begin
                        best_err = err;
                        best_sc  = 64'(sc);
                        best_st  = st;
                    end
                end
            end
            res.scale = best_sc[SCALE_W-1:0];
            res.step  = best_st[STEP_W-1:0];
            res.err   = best_err[ERR_W-1:0];
            predicted_q.push_back(res);
            requests_seen++;
        endfunction

        function void check_result(search_result_t got);
            search_result_t want;
            results_seen++;
            if (predicted_q.size() == 0) begin
                $display("%0t: result with no request pending: scale %0d step %0d error %0d",
                         $time, got.scale, got.step, got.err);
                mismatches++;
                return;
            end
            want = predicted_q.pop_front();
            if (got.scale !== want.scale) begin
                $display("%0t: best_scale expected %0d got %0d", $time, want.scale, got.scale);
                mismatches++;
            end
            if (got.step !== want.step) begin
                $display("%0t: best_step expected %0d got %0d", $time, want.step, got.step);
                mismatches++;
            end
            if (got.err !== want.err) begin
                $display("%0t: rate_error expected %0d got %0d", $time, want.err, got.err);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ubss_baud_if   req_ch ();
    ubss_result_if rsp_ch ();
    ubss_cfg_if    cfg_ch ();

    uart_baud_scale_step_search_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    baud_search_scoreboard sb = new();

    bit req_no_idle;
    bit rsp_no_idle;
    bit hold_request;
    int clock_settings;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // keep most searches short: baud close to the clock means few scales
    function automatic logic [BAUD_W-1:0] random_baud(logic [CLK_W-1:0] hz);
        int          r;
        logic [31:0] lo;
        r  = $urandom_range(0, 99);
        lo = 32'(hz) / 64;
        if (lo > 32'(BAUD_MAX))
            lo = 32'(BAUD_MAX);
        if (r < 5)
            return BAUD_W'($urandom_range(0, 20000));
        else if (r < 20)
            return BAUD_W'($urandom_range(0, 32'(BAUD_MAX)));
        else
            return BAUD_W'($urandom_range(lo, 32'(BAUD_MAX)));
    endfunction

    task automatic send_baud(logic [BAUD_W-1:0] baud);
        int gap;
        gap = pick_gap(req_no_idle);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.baud_rate <= baud;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(baud);
    endtask

    task automatic wait_for_idle();
        req_ch.valid <= 1'b0;
        while (sb.predicted_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] hz);
        wait_for_idle();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.clock_hz <= hz;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.set_clock(hz);
        clock_settings++;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin : result_side
        int             stall_left;
        int             hold_left;
        search_result_t got;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_ch.valid && rsp_ch.ready)
                begin
                    got.scale = rsp_ch.best_scale;
                    got.step  = rsp_ch.best_step;
                    got.err   = rsp_ch.rate_error;
                    sb.check_result(got);
                    stall_left = pick_gap(rsp_no_idle);
                end
                if (hold_request)
                begin
                    hold_left    = HOLD_CYCLES;
                    hold_request = 1'b0;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    rsp_ch.ready <= 1'b0;
                end
                else if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [CLK_W-1:0] phase_clk[5];
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.baud_rate = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.clock_hz  = '0;
        req_no_idle      = 1'b0;
        rsp_no_idle      = 1'b0;
        hold_request     = 1'b0;
        clock_settings   = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset clock: zero baud, full-length search, immediate stop, bit patterns
        send_baud('0);
        send_baud(BAUD_W'(1));
        send_baud(BAUD_MAX);
        send_baud(BAUD_W'(24'hAAAAAA));
        send_baud(BAUD_W'(24'h555555));
        send_baud(BAUD_W'(115200));
        send_baud(BAUD_W'(9600));
        send_baud(BAUD_W'(921600));

        // long result hold-off while requests keep coming
        req_no_idle  = 1'b1;
        hold_request = 1'b1;
        repeat (6) send_baud(BAUD_W'($urandom_range(3000000, 32'(BAUD_MAX))));
        req_no_idle = 1'b0;

        // zero clock: no scale tried
        write_clock('0);
        send_baud('0);
        send_baud(BAUD_W'(123456));
        send_baud(BAUD_MAX);

        write_clock(CLK_MAX);
        send_baud(BAUD_W'(1));
        send_baud(BAUD_MAX);
        send_baud(BAUD_W'(115200));

        write_clock(CLK_W'(1000000));
        send_baud(BAUD_W'(1000000));
        send_baud(BAUD_MAX);
        send_baud(BAUD_W'(300));

        write_clock(CLK_W'(200000000));
        send_baud(BAUD_W'(4000000));
        send_baud(BAUD_W'(115200));

        phase_clk[0] = CLK_W'(40000000);
        phase_clk[1] = CLK_W'(200000000);
        phase_clk[2] = CLK_W'($urandom_range(1000000, 200000000));
        phase_clk[3] = CLK_W'($urandom_range(0, 32'(CLK_MAX)));
        phase_clk[4] = CLK_W'(1000000);
        for (int p = 0; p < 5; p++)
        begin
            write_clock(phase_clk[p]);
            // one phase with both sides running back to back
            req_no_idle = (p == 2);
            rsp_no_idle = (p == 2);
            repeat (PHASE_ITEMS) send_baud(random_baud(phase_clk[p]));
        end
        req_no_idle = 1'b0;
        rsp_no_idle = 1'b0;

        wait_for_idle();
        repeat (END_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d baud requests under %0d clock settings,",
                 sb.results_seen, sb.requests_seen, clock_settings);
        $display("clock from zero through 1 MHz and 200 MHz to the 28-bit maximum.");
        if (sb.mismatches == 0 && sb.predicted_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
